// ----- sv/stq_pkg.sv -----
// Shared types and constants for the session timeout queue.
// Holds command and result records, status codes and register indexes.
// Depends on nothing.
`default_nettype none

package stq_pkg;

    localparam int THREADS_DEF = 4;
    localparam int ENTRIES_DEF = 256;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH   = 1'b1;

    localparam logic [31:0] TIMEOUT_RST = 32'd60;
    localparam logic [5:0]  BATCH_RST   = 6'd63;

    typedef enum logic [1:0] {
        OP_UPSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INSERTED = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_op         op;
        logic        in_range;
        logic [1:0]  thread;
        logic [63:0] key;
        logic [31:0] user;
        logic [31:0] now;
        logic [31:0] expiry;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [63:0] key;
        logic [31:0] user;
        t_status     status;
        logic [8:0]  occ;
        logic        last;
    } t_res;

endpackage

`default_nettype wire

// ----- sv/stq_fifo.sv -----
// Small register queue used between the front, the engine and the result ports.
// Generic in width and depth; depends on nothing.
`default_nettype none

module stq_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    output logic         o_full,
    input  wire  [W-1:0] i_data,
    output logic         o_empty,
    input  wire          i_pop,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/stq_front.sv -----
// Front stage: takes input transactions, classifies the command and the
// thread range, and forms the expiry time. Depends on stq_pkg.
`default_nettype none

module stq_front #(
    parameter int THREADS = stq_pkg::THREADS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_full,
    input  wire  [1:0]         i_cmd,
    input  wire  [1:0]         i_thread_index,
    input  wire  [63:0]        i_session_key,
    input  wire  [31:0]        i_user_word,
    input  wire  [31:0]        i_now_secs,
    input  wire  [31:0]        i_timeout,
    output logic               o_vld,
    output stq_pkg::t_cmd      o_cmd,
    input  wire                i_take
);
    import stq_pkg::*;

    logic r_vld;
    t_cmd r_cmd;
    logic w_acc;

    assign o_full = r_vld && !i_take;
    assign w_acc  = i_push && !o_full;
    assign o_vld  = r_vld;
    assign o_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd.op       <= t_op'(i_cmd);
            r_cmd.in_range <= (32'(i_thread_index) < THREADS);
            r_cmd.thread   <= i_thread_index;
            r_cmd.key      <= i_session_key;
            r_cmd.user     <= i_user_word;
            r_cmd.now      <= i_now_secs;
            r_cmd.expiry   <= i_now_secs + i_timeout;
        end
    end

endmodule

`default_nettype wire

// ----- sv/stq_engine.sv -----
// Back part: carries out one command at a time on the entry memories and
// the per-thread linked lists. Depends on stq_pkg.
`default_nettype none

module stq_engine #(
    parameter int THREADS = stq_pkg::THREADS_DEF,
    parameter int ENTRIES = stq_pkg::ENTRIES_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cmd_empty,
    output logic           o_cmd_pop,
    input  stq_pkg::t_cmd  i_cmd,
    input  wire  [5:0]     i_batch,
    output logic           o_res_push,
    input  wire            i_res_full,
    output stq_pkg::t_res  o_res
);
    import stq_pkg::*;

    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int SW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int AW    = TW + SW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [13:0] {
        S_CLEAR     = 14'h0001,
        S_IDLE      = 14'h0002,
        S_SRCH_RD   = 14'h0004,
        S_SRCH_CHK  = 14'h0008,
        S_FREE_RD   = 14'h0010,
        S_FREE_CHK  = 14'h0020,
        S_UNLINK    = 14'h0040,
        S_LINK      = 14'h0080,
        S_TICK_RD   = 14'h0100,
        S_TICK_CHK  = 14'h0200,
        S_FLUSH_RD  = 14'h0400,
        S_FLUSH_CHK = 14'h0800,
        S_DONE      = 14'h1000,
        S_SPARE     = 14'h2000
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    t_status       r_status, n_status;
    logic [SW-1:0] r_cur, n_cur, r_slot, n_slot, r_p, n_p, r_n, n_n;
    logic [CW-1:0] r_left, n_left, r_scan, n_scan;
    logic [5:0]    r_tleft, n_tleft;
    logic [AW-1:0] r_clr;

    logic [SW-1:0] r_head [THREADS];
    logic [SW-1:0] r_tail [THREADS];
    logic [CW-1:0] r_count [THREADS];

    logic [63:0]   mem_key  [DEPTH];
    logic [31:0]   mem_user [DEPTH];
    logic [31:0]   mem_exp  [DEPTH];
    logic [SW-1:0] mem_next [DEPTH];
    logic [SW-1:0] mem_prev [DEPTH];
    logic          mem_vld  [DEPTH];

    logic [63:0]   rd_key;
    logic [31:0]   rd_user, rd_exp;
    logic [SW-1:0] rd_next, rd_prev;
    logic          rd_vld;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we_vld, wd_vld, we_kv, we_exp, we_next, we_prev;
    logic [AW-1:0] wa_vld, wa_kv, wa_exp, wa_next, wa_prev;
    logic [31:0]   wd_exp;
    logic [SW-1:0] wd_next, wd_prev;

    logic          hd_we, tl_we, ct_we, latch;
    logic [SW-1:0] hd_d, tl_d;
    logic [CW-1:0] ct_d;

    logic [TW-1:0] w_t, w_it;
    logic [SW-1:0] w_h, w_tl;
    logic [CW-1:0] w_c;

    assign w_t  = TW'(r_cmd.thread);
    assign w_it = TW'(i_cmd.thread);
    assign w_h  = r_head[w_t];
    assign w_tl = r_tail[w_t];
    assign w_c  = r_count[w_t];

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_cur      = r_cur;
        n_slot     = r_slot;
        n_p        = r_p;
        n_n        = r_n;
        n_left     = r_left;
        n_scan     = r_scan;
        n_tleft    = r_tleft;
        latch      = 1'b0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        rd_en      = 1'b0;
        rd_addr    = {w_t, r_cur};
        we_vld     = 1'b0;
        wa_vld     = {w_t, r_slot};
        wd_vld     = 1'b0;
        we_kv      = 1'b0;
        wa_kv      = {w_t, r_slot};
        we_exp     = 1'b0;
        wa_exp     = {w_t, r_slot};
        wd_exp     = r_cmd.expiry;
        we_next    = 1'b0;
        wa_next    = {w_t, r_p};
        wd_next    = r_n;
        we_prev    = 1'b0;
        wa_prev    = {w_t, r_n};
        wd_prev    = r_p;
        hd_we      = 1'b0;
        hd_d       = r_n;
        tl_we      = 1'b0;
        tl_d       = r_p;
        ct_we      = 1'b0;
        ct_d       = w_c;

        case (r_state)
            S_CLEAR: begin
                we_vld = 1'b1;
                wa_vld = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    latch     = 1'b1;
                    n_status  = ST_OK;
                    n_cur     = r_head[w_it];
                    n_left    = r_count[w_it];
                    n_scan    = '0;
                    n_tleft   = i_batch;
                    if (!i_cmd.in_range) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else begin
                        case (i_cmd.op)
                            OP_UPSERT, OP_REMOVE: n_state = S_SRCH_RD;
                            OP_TICK:              n_state = S_TICK_RD;
                            OP_FLUSH:             n_state = S_FLUSH_RD;
                            default:              n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_SRCH_RD: begin
                if (r_left == '0) begin
                    if (r_cmd.op == OP_UPSERT) begin
                        n_state = S_FREE_RD;
                    end else begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (rd_key == r_cmd.key) begin
                    n_slot  = r_cur;
                    n_p     = rd_prev;
                    n_n     = rd_next;
                    n_state = S_UNLINK;
                end else begin
                    n_cur   = rd_next;
                    n_left  = r_left - 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_FREE_RD: begin
                if (r_scan == CW'(ENTRIES)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = {w_t, r_scan[SW-1:0]};
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (!rd_vld) begin
                    n_slot   = r_scan[SW-1:0];
                    we_vld   = 1'b1;
                    wd_vld   = 1'b1;
                    wa_vld   = {w_t, r_scan[SW-1:0]};
                    we_kv    = 1'b1;
                    wa_kv    = {w_t, r_scan[SW-1:0]};
                    we_exp   = 1'b1;
                    wa_exp   = {w_t, r_scan[SW-1:0]};
                    n_status = ST_INSERTED;
                    n_state  = S_LINK;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_state = S_FREE_RD;
                end
            end
            S_UNLINK: begin
                if (!(r_cmd.op == OP_TICK && i_res_full)) begin
                    if (w_h == r_slot) begin
                        hd_we = 1'b1;
                    end else begin
                        we_next = 1'b1;
                    end
                    if (w_tl == r_slot) begin
                        tl_we = 1'b1;
                    end else begin
                        we_prev = 1'b1;
                    end
                    if (w_c != '0) begin
                        ct_we = 1'b1;
                        ct_d  = w_c - 1'b1;
                    end
                    case (r_cmd.op)
                        OP_UPSERT: begin
                            we_exp  = 1'b1;
                            n_state = S_LINK;
                        end
                        OP_REMOVE: begin
                            we_vld  = 1'b1;
                            n_state = S_DONE;
                        end
                        OP_TICK: begin
                            we_vld     = 1'b1;
                            o_res_push = 1'b1;
                            o_res.key  = rd_key;
                            o_res.user = rd_user;
                            o_res.occ  = 9'(ct_d);
                            n_tleft    = r_tleft - 1'b1;
                            n_state    = S_TICK_RD;
                        end
                        default: begin
                            we_vld  = 1'b1;
                            n_state = S_FLUSH_RD;
                        end
                    endcase
                end
            end
            S_LINK: begin
                if (w_c == '0) begin
                    hd_we = 1'b1;
                    hd_d  = r_slot;
                end else begin
                    we_next = 1'b1;
                    wa_next = {w_t, w_tl};
                    wd_next = r_slot;
                    we_prev = 1'b1;
                    wa_prev = {w_t, r_slot};
                    wd_prev = w_tl;
                end
                tl_we   = 1'b1;
                tl_d    = r_slot;
                ct_we   = 1'b1;
                ct_d    = w_c + 1'b1;
                n_state = S_DONE;
            end
            S_TICK_RD: begin
                if (r_tleft == '0 || w_c == '0) begin
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = {w_t, w_h};
                    n_state = S_TICK_CHK;
                end
            end
            S_TICK_CHK: begin
                if (rd_exp >= r_cmd.now) begin
                    n_state = S_DONE;
                end else begin
                    n_slot  = w_h;
                    n_p     = rd_prev;
                    n_n     = rd_next;
                    n_state = S_UNLINK;
                end
            end
            S_FLUSH_RD: begin
                if (w_c == '0) begin
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = {w_t, w_h};
                    n_state = S_FLUSH_CHK;
                end
            end
            S_FLUSH_CHK: begin
                n_slot  = w_h;
                n_p     = rd_prev;
                n_n     = rd_next;
                n_state = S_UNLINK;
            end
            S_DONE: begin
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res.kind   = 1'b1;
                    o_res.status = r_status;
                    o_res.occ    = r_cmd.in_range ? 9'(w_c) : '0;
                    o_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            for (int k = 0; k < THREADS; k++) begin
                r_head[k]  <= '0;
                r_tail[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (hd_we) begin
                r_head[w_t] <= hd_d;
            end
            if (tl_we) begin
                r_tail[w_t] <= tl_d;
            end
            if (ct_we) begin
                r_count[w_t] <= ct_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (latch) begin
            r_cmd <= i_cmd;
        end
        r_status <= n_status;
        r_cur    <= n_cur;
        r_slot   <= n_slot;
        r_p      <= n_p;
        r_n      <= n_n;
        r_left   <= n_left;
        r_scan   <= n_scan;
        r_tleft  <= n_tleft;
    end

    always_ff @(posedge i_clk) begin
        if (we_kv) begin
            mem_key[wa_kv]  <= r_cmd.key;
            mem_user[wa_kv] <= r_cmd.user;
        end
        if (rd_en) begin
            rd_key  <= mem_key[rd_addr];
            rd_user <= mem_user[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_exp) begin
            mem_exp[wa_exp] <= wd_exp;
        end
        if (rd_en) begin
            rd_exp <= mem_exp[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_next) begin
            mem_next[wa_next] <= wd_next;
        end
        if (rd_en) begin
            rd_next <= mem_next[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_prev) begin
            mem_prev[wa_prev] <= wd_prev;
        end
        if (rd_en) begin
            rd_prev <= mem_prev[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_vld) begin
            mem_vld[wa_vld] <= wd_vld;
        end
        if (rd_en) begin
            rd_vld <= mem_vld[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/session_timeout_queue_unit.sv -----
// Top level of the session timeout queue: configuration registers, front
// stage, command queue, engine and result queue.
//
// One keyed timeout queue per thread, each a linked list ordered by last
// refresh. Commands are processed one at a time by the engine, while the
// front and the command queue keep taking transactions. For an upsert or a
// remove a key lookup walks the thread's list entry by entry; an upsert of a
// new key then scans for the lowest free slot, and relinking and the done
// result follow. A tick unlinks expired entries from the head of the list,
// a flush every entry. After reset the engine clears the valid bits of every
// slot in its entry memories (1024 at the default sizes), one per cycle,
// before it starts the first command. Depends on stq_pkg, stq_front,
// stq_fifo and stq_engine.
`default_nettype none

module session_timeout_queue_unit #(
    parameter int THREADS = stq_pkg::THREADS_DEF,
    parameter int ENTRIES = stq_pkg::ENTRIES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              push,
    output logic                             full,
    input  wire  [1:0]                       i_cmd,
    input  wire  [1:0]                       i_thread_index,
    input  wire  [63:0]                      i_session_key,
    input  wire  [31:0]                      i_user_word,
    input  wire  [31:0]                      i_now_secs,
    output logic                             empty,
    input  wire                              pop,
    output logic                             o_kind,
    output logic [63:0]                      o_expired_key,
    output logic [31:0]                      o_expired_user,
    output logic [1:0]                       o_status,
    output logic [8:0]                       o_occupancy,
    output logic                             o_last,
    input  wire                              i_cfg_we,
    input  wire  [stq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [stq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import stq_pkg::*;

    logic [31:0] r_timeout;
    logic [5:0]  r_batch;

    logic        f_vld, f_take, q_full, q_empty, q_pop, r_push, r_full;
    t_cmd        f_cmd, q_cmd;
    t_res        e_res, o_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_batch   <= BATCH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_BATCH:   r_batch   <= i_cfg_data[5:0];
                default:     r_batch   <= r_batch;
            endcase
        end
    end

    stq_front #(.THREADS(THREADS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_cmd          (i_cmd),
        .i_thread_index (i_thread_index),
        .i_session_key  (i_session_key),
        .i_user_word    (i_user_word),
        .i_now_secs     (i_now_secs),
        .i_timeout      (r_timeout),
        .o_vld          (f_vld),
        .o_cmd          (f_cmd),
        .i_take         (f_take)
    );

    assign f_take = f_vld && !q_full;

    stq_fifo #(.W($bits(t_cmd)), .DEPTH(2)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .o_full  (q_full),
        .i_data  (f_cmd),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    stq_engine #(.THREADS(THREADS), .ENTRIES(ENTRIES)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_cmd),
        .i_batch     (r_batch),
        .o_res_push  (r_push),
        .i_res_full  (r_full),
        .o_res       (e_res)
    );

    stq_fifo #(.W($bits(t_res)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_push),
        .o_full  (r_full),
        .i_data  (e_res),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_res)
    );

    assign o_kind         = o_res.kind;
    assign o_expired_key  = o_res.key;
    assign o_expired_user = o_res.user;
    assign o_status       = o_res.status;
    assign o_occupancy    = o_res.occ;
    assign o_last         = o_res.last;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for session_timeout_queue_unit: directed table rows, a full table, zero
// batch and random traffic, checked by a behavioral queue model or a row's result.
// Depends on stq_pkg and the session_timeout_queue_unit RTL.
`default_nettype none

module tb;
    import stq_pkg::*;

    localparam int NTHR = 4;
    localparam int NENT = 256;

    typedef struct {
        t_op         op;
        logic [1:0]  thr;
        logic [63:0] key;
        logic [31:0] user;
        logic [31:0] now;
        logic        has_exp;
        t_res        exp_res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [1:0]  i_cmd = '0;
    logic [1:0]  i_thread_index = '0;
    logic [63:0] i_session_key = '0;
    logic [31:0] i_user_word = '0;
    logic [31:0] i_now_secs = '0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    wire         full, empty, o_kind, o_last;
    wire  [63:0] o_expired_key;
    wire  [31:0] o_expired_user;
    wire  [1:0]  o_status;
    wire  [8:0]  o_occupancy;

    session_timeout_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_cmd(i_cmd), .i_thread_index(i_thread_index),
        .i_session_key(i_session_key), .i_user_word(i_user_word),
        .i_now_secs(i_now_secs), .empty(empty), .pop(pop),
        .o_kind(o_kind), .o_expired_key(o_expired_key),
        .o_expired_user(o_expired_user), .o_status(o_status),
        .o_occupancy(o_occupancy), .o_last(o_last),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [63:0] slot_key [NTHR][NENT];
    logic [31:0] slot_user [NTHR][NENT];
    logic [31:0] slot_expiry [NTHR][NENT];
    logic        slot_valid [NTHR][NENT];
    int          order_q [NTHR][$];
    logic [31:0] timeout_reg;
    logic [5:0]  batch_reg;

    t_res pending_res [$];
    int   errors = 0;
    int   results_seen = 0;
    int   expired_seen = 0;
    int   send_idle = 0;
    int   recv_idle = 0;

    function automatic t_res make_res(logic kind, logic [63:0] key, logic [31:0] user,
                                      t_status st, int occ, logic last);
        t_res r;
        r.kind = kind; r.key = key; r.user = user; r.status = st;
        r.occ = occ[8:0]; r.last = last;
        return r;
    endfunction

    task automatic predict_queue(t_op op, logic [1:0] thr, logic [63:0] key,
                                 logic [31:0] user, logic [31:0] now);
        int t, pos, s, left;
        t_status st;
        t = thr;
        pos = -1;
        st = ST_OK;
        for (int j = 0; j < order_q[t].size(); j++) begin
            if (slot_key[t][order_q[t][j]] == key) pos = j;
        end
        case (op)
            OP_UPSERT: begin
                if (pos >= 0) begin
                    s = order_q[t][pos];
                    order_q[t].delete(pos);
                    order_q[t].push_back(s);
                    slot_expiry[t][s] = now + timeout_reg;
                end else begin
                    s = -1;
                    for (int j = NENT - 1; j >= 0; j--) if (!slot_valid[t][j]) s = j;
                    if (s < 0) begin
                        st = ST_FULL;
                    end else begin
                        slot_valid[t][s] = 1'b1;
                        slot_key[t][s] = key;
                        slot_user[t][s] = user;
                        slot_expiry[t][s] = now + timeout_reg;
                        order_q[t].push_back(s);
                        st = ST_INSERTED;
                    end
                end
            end
            OP_REMOVE: begin
                if (pos >= 0) begin
                    slot_valid[t][order_q[t][pos]] = 1'b0;
                    order_q[t].delete(pos);
                end else begin
                    st = ST_NOTFOUND;
                end
            end
            OP_TICK: begin
                left = batch_reg;
                while (left > 0 && order_q[t].size() > 0) begin
                    s = order_q[t][0];
                    if (slot_expiry[t][s] >= now) break;
                    void'(order_q[t].pop_front());
                    slot_valid[t][s] = 1'b0;
                    pending_res.push_back(make_res(1'b0, slot_key[t][s], slot_user[t][s],
                                                   ST_OK, order_q[t].size(), 1'b0));
                    left--;
                end
            end
            default: begin
                for (int j = 0; j < order_q[t].size(); j++) begin
                    slot_valid[t][order_q[t][j]] = 1'b0;
                end
                order_q[t].delete();
            end
        endcase
        pending_res.push_back(make_res(1'b1, '0, '0, st, order_q[t].size(), 1'b1));
    endtask

    // The push request stays high after a transaction; the next call, an idle
    // cycle or a drain replaces or drops it in the same time step.
    task automatic send_item(t_op op, logic [1:0] thr, logic [63:0] key,
                             logic [31:0] user, logic [31:0] now);
        while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= op;
        i_thread_index <= thr;
        i_session_key <= key;
        i_user_word <= user;
        i_now_secs <= now;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_queue(op, thr, key, user, now);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_res.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TIMEOUT) timeout_reg = val;
        else batch_reg = val[5:0];
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (!o_kind) expired_seen++;
            if (pending_res.size() == 0) begin
                errors++;
                $display("%0t unexpected result kind=%0d key=%h", $time, o_kind,
                         o_expired_key);
            end else begin
                want = pending_res.pop_front();
                if (o_kind !== want.kind || o_expired_key !== want.key ||
                    o_expired_user !== want.user || o_status !== want.status ||
                    o_occupancy !== want.occ || o_last !== want.last) begin
                    errors++;
                    $display("%0t mismatch expected kind=%0d key=%h user=%h st=%0d occ=%0d last=%0d",
                             $time, want.kind, want.key, want.user, want.status,
                             want.occ, want.last);
                    $display("%0t            actual kind=%0d key=%h user=%h st=%0d occ=%0d last=%0d",
                             $time, o_kind, o_expired_key, o_expired_user, o_status,
                             o_occupancy, o_last);
                end
            end
        end
        pop <= (recv_idle == 0) || ($urandom_range(99, 0) >= recv_idle);
    end

    t_row dir_rows [$];

    task automatic add_row(t_op op, logic [1:0] thr, logic [63:0] key, logic [31:0] user,
                           logic [31:0] now, logic has_exp, t_res r);
        t_row w;
        w.op = op; w.thr = thr; w.key = key; w.user = user; w.now = now;
        w.has_exp = has_exp; w.exp_res = r;
        dir_rows.push_back(w);
    endtask

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_res none;
        t_op op;
        int pick, thr, phase;
        logic [63:0] key;
        logic [63:0] key_pool [0:7];
        logic [31:0] now_base [NTHR];
        none = make_res(1'b0, '0, '0, ST_OK, 0, 1'b0);
        timeout_reg = TIMEOUT_RST;
        batch_reg = BATCH_RST;
        foreach (slot_valid[t, j]) slot_valid[t][j] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(OP_REMOVE, 2'd0, 64'd5, 32'd0, 32'd0, 1'b1,
                make_res(1'b1, '0, '0, ST_NOTFOUND, 0, 1'b1));
        add_row(OP_TICK, 2'd1, 64'd0, 32'd0, 32'hFFFF_FFFF, 1'b1,
                make_res(1'b1, '0, '0, ST_OK, 0, 1'b1));
        add_row(OP_UPSERT, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1,
                make_res(1'b1, '0, '0, ST_INSERTED, 1, 1'b1));
        add_row(OP_UPSERT, 2'd0, 64'd0, 32'd0, 32'd10, 1'b1,
                make_res(1'b1, '0, '0, ST_INSERTED, 2, 1'b1));
        add_row(OP_UPSERT, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234, 32'd20, 1'b0, none);
        add_row(OP_TICK, 2'd0, 64'd0, 32'd0, 32'd70, 1'b0, none);
        add_row(OP_TICK, 2'd0, 64'd0, 32'd0, 32'd81, 1'b0, none);
        add_row(OP_UPSERT, 2'd3, 64'hA5A5, 32'h5A5A_5A5A, 32'hFFFF_FFF0, 1'b0, none);
        add_row(OP_UPSERT, 2'd3, 64'hA5A6, 32'h1, 32'h7FFF_FFFF, 1'b0, none);
        add_row(OP_REMOVE, 2'd3, 64'hA5A5, 32'd0, 32'd0, 1'b0, none);
        add_row(OP_UPSERT, 2'd3, 64'hA5A7, 32'h2, 32'd0, 1'b0, none);
        add_row(OP_FLUSH, 2'd3, 64'd0, 32'd0, 32'd0, 1'b1,
                make_res(1'b1, '0, '0, ST_OK, 0, 1'b1));
        add_row(OP_REMOVE, 2'd3, 64'hA5A6, 32'd0, 32'd0, 1'b1,
                make_res(1'b1, '0, '0, ST_NOTFOUND, 0, 1'b1));
        add_row(OP_UPSERT, 2'd2, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'd5, 1'b0, none);
        add_row(OP_TICK, 2'd2, 64'd0, 32'd0, 32'd65, 1'b0, none);
        add_row(OP_TICK, 2'd2, 64'd0, 32'd0, 32'd66, 1'b0, none);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].has_exp) begin
                drain_results();
                send_item(dir_rows[n].op, dir_rows[n].thr, dir_rows[n].key,
                          dir_rows[n].user, dir_rows[n].now);
                pending_res.delete();
                pending_res.push_back(dir_rows[n].exp_res);
            end else begin
                send_item(dir_rows[n].op, dir_rows[n].thr, dir_rows[n].key,
                          dir_rows[n].user, dir_rows[n].now);
            end
        end
        drain_results();

        // Fill thread 1 to capacity to reach the table-full status.
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        for (int j = 0; j < NENT; j++) send_item(OP_UPSERT, 2'd1, 64'h100 + j, j, 32'd1);
        send_item(OP_UPSERT, 2'd1, 64'h9999, 32'd7, 32'd1);
        send_item(OP_REMOVE, 2'd1, 64'h105, 32'd0, 32'd0);
        send_item(OP_UPSERT, 2'd1, 64'h9999, 32'd7, 32'd1);
        send_item(OP_TICK, 2'd1, 64'd0, 32'd0, 32'd1);
        send_item(OP_FLUSH, 2'd1, 64'd0, 32'd0, 32'd0);
        drain_results();

        // Zero batch means a tick removes nothing.
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_BATCH, 32'd0);
        send_item(OP_UPSERT, 2'd0, 64'h77, 32'h77, 32'd0);
        send_item(OP_TICK, 2'd0, 64'd0, 32'd0, 32'hFFFF_FFFF);
        drain_results();

        for (phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 47 : 22) : 0;
            recv_idle = (phase == 2 || phase == 3) ? (phase == 2 ? 47 : 22) : 0;
            write_reg(CFG_TIMEOUT, (phase == 0) ? 32'd3 : $urandom_range(12, 0));
            write_reg(CFG_BATCH, (phase == 1) ? 32'd1 : ((phase == 2) ? 32'd63 :
                                  $urandom_range(8, 1)));
            foreach (key_pool[j]) key_pool[j] = {$urandom, $urandom};
            foreach (now_base[j]) now_base[j] = (phase == 3) ? 32'hFFFF_FFF0 : $urandom;
            for (int n = 0; n < 40; n++) begin
                thr = $urandom_range(3, 0);
                pick = $urandom_range(99, 0);
                now_base[thr] += $urandom_range(4, 0);
                key = ($urandom_range(9, 0) == 0) ? {$urandom, $urandom} :
                      key_pool[$urandom_range(7, 0)];
                if (pick < 45) op = OP_UPSERT;
                else if (pick < 65) op = OP_REMOVE;
                else if (pick < 95) op = OP_TICK;
                else op = OP_FLUSH;
                send_item(op, thr[1:0], key, $urandom, now_base[thr]);
                if (n == 20 && phase == 1) drain_results();
            end
            drain_results();
        end

        $display("Covered directed corners, a full table, zero batch and random traffic.");
        $display("Checked %0d results, %0d of them expired-entry reports.",
                 results_seen, expired_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
